// File: hw/rtl/yaw_pitch_forward_vector_top_assert.svh
// Assertion macros for the yaw/pitch forward vector block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef YAW_PITCH_FORWARD_VECTOR_TOP_ASSERT_SVH
`define YAW_PITCH_FORWARD_VECTOR_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define YPFV_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// A value stays within plus or minus a limit while its qualifier is high.
`define YPFV_ASSERT_RANGE(name, qual, val, lim, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (qual) |-> (((val) <= (lim)) && ((val) >= -(lim)))) else $error(msg);

`endif

// File: hw/rtl/ypfv_pkg.sv
// Package for the yaw/pitch forward vector block: constants, types and
// fixed-point helper functions. No dependencies.
package ypfv_pkg;

  localparam int ANGLE_FRAC_BITS = 20;
  localparam int OUT_FRAC_BITS   = 30;
  localparam int TO_Q32          = 32 - ANGLE_FRAC_BITS;
  localparam int IN_W            = 48;
  localparam int OUT_W           = 32;
  localparam int QBITS           = 24;
  localparam int REM_W           = 60;
  localparam int NUM_TERMS       = 7;
  localparam int NUM_FIX         = 2;
  localparam int RECIP_SHIFT     = 27;
  localparam int RECIP_W         = 25;

  localparam logic [63:0] PI_Q32        = 64'h3_243F_6A89;
  localparam logic [63:0] HALF_PI_Q32   = 64'h1_921F_B544;
  localparam logic [63:0] TWO_PI_HI     = 64'h6_487E_D511;
  localparam logic [63:0] TWO_PI_LO     = 64'h0B46_11A6;
  localparam logic [63:0] PITCH_LIM_Q32 = 64'd6746517449;
  localparam logic [63:0] YAW_LIMIT     = 64'd100000000 << ANGLE_FRAC_BITS;
  localparam logic [63:0] RECIP         = (64'd1 << (RECIP_SHIFT + 32)) / TWO_PI_HI;
  localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;

  localparam logic signed [63:0] SIN_COEF [NUM_TERMS] = '{
    (ONE_Q60 + 64'sd3113510400) / 64'sd6227020800,
    -((ONE_Q60 + 64'sd19958400) / 64'sd39916800),
    (ONE_Q60 + 64'sd181440) / 64'sd362880,
    -((ONE_Q60 + 64'sd2520) / 64'sd5040),
    (ONE_Q60 + 64'sd60) / 64'sd120,
    -((ONE_Q60 + 64'sd3) / 64'sd6),
    ONE_Q60
  };
  localparam logic signed [63:0] COS_COEF [NUM_TERMS] = '{
    (ONE_Q60 + 64'sd239500800) / 64'sd479001600,
    -((ONE_Q60 + 64'sd1814400) / 64'sd3628800),
    (ONE_Q60 + 64'sd20160) / 64'sd40320,
    -((ONE_Q60 + 64'sd360) / 64'sd720),
    (ONE_Q60 + 64'sd12) / 64'sd24,
    -((ONE_Q60 + 64'sd1) / 64'sd2),
    ONE_Q60
  };

  typedef struct packed {
    logic signed [IN_W-1:0] yaw_angle;
    logic signed [IN_W-1:0] pitch_angle;
  } ypfv_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] forward_x;
    logic signed [OUT_W-1:0] forward_y;
    logic signed [OUT_W-1:0] forward_z;
  } ypfv_out_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] quot;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t yaw;
    div_lane_t pitch;
  } div_item_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] x2;
    logic signed [63:0] acc_s;
    logic signed [63:0] acc_c;
    logic               flip;
  } poly_lane_t;

  typedef struct packed {
    poly_lane_t yaw;
    poly_lane_t pitch;
  } poly_item_t;

  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
    logic        neg;
  } pp_t;

  function automatic logic [63:0] umag(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [63:0] apply_sign(input logic [62:0] m, input logic neg);
    logic signed [63:0] s;
    s = {1'b0, m};
    return neg ? -s : s;
  endfunction

  function automatic pp_t mul_pp(input logic signed [63:0] a, input logic signed [63:0] b);
    pp_t p;
    logic [63:0] ua;
    logic [63:0] ub;
    ua = umag(a);
    ub = umag(b);
    p.p00 = ua[31:0] * ub[31:0];
    p.p01 = ua[31:0] * ub[63:32];
    p.p10 = ua[63:32] * ub[31:0];
    p.p11 = ua[63:32] * ub[63:32];
    p.neg = a[63] ^ b[63];
    return p;
  endfunction

  function automatic logic signed [63:0] mul_fin(input pp_t p, input int n);
    logic [127:0] s;
    logic [127:0] r;
    s = {64'd0, p.p00} + ({64'd0, p.p01} << 32) + ({64'd0, p.p10} << 32)
        + {p.p11, 64'd0};
    r = (s + (128'd1 << (n - 1))) >> n;
    return apply_sign(r[62:0], p.neg);
  endfunction

  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v, input int n);
    logic [63:0] t;
    if (n == 0) begin
      return v;
    end
    t = (umag(v) + (64'd1 << (n - 1))) >> n;
    return apply_sign(t[62:0], v[63]);
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [63:0] v30);
    logic signed [63:0] v;
    logic signed [63:0] one;
    one = 64'sd1 <<< OUT_FRAC_BITS;
    v = shr_round(v30, 30 - OUT_FRAC_BITS);
    if (v > one) begin
      v = one;
    end
    if (v < -one) begin
      v = -one;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/ypfv_div_cell.sv
// One correction cell of the revolution-count divider: subtracts the divisor
// once while the remainder still reaches it. Depends on ypfv_pkg.
module ypfv_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [ypfv_pkg::REM_W-1:0] div_i,
  input  ypfv_pkg::div_item_t item_i,
  output logic                valid_o,
  output ypfv_pkg::div_item_t item_o
);
  import ypfv_pkg::*;

  logic      valid_q;
  div_item_t item_d;
  div_item_t item_q;

  function automatic div_lane_t step(input div_lane_t l, input logic [REM_W-1:0] d);
    div_lane_t o;
    logic      take;
    take   = (l.rem >= d);
    o.rem  = take ? (l.rem - d) : l.rem;
    o.quot = l.quot + {{(QBITS-1){1'b0}}, take};
    o.neg  = l.neg;
    return o;
  endfunction

  always_comb begin
    item_d.yaw   = step(item_i.yaw, div_i);
    item_d.pitch = step(item_i.pitch, div_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/ypfv_poly_cell.sv
// One Horner step of the sine and cosine polynomials for both angles,
// split over a partial-product stage and a summing stage. Depends on ypfv_pkg.
module ypfv_poly_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [63:0]         sin_coef_i,
  input  logic signed [63:0]         cos_coef_i,
  input  ypfv_pkg::poly_item_t       item_i,
  output logic                       valid_o,
  output ypfv_pkg::poly_item_t       item_o
);
  import ypfv_pkg::*;

  logic       valid_a_q;
  poly_item_t item_a_q;
  pp_t        pp_ys_q;
  pp_t        pp_yc_q;
  pp_t        pp_ps_q;
  pp_t        pp_pc_q;
  logic       valid_b_q;
  poly_item_t item_b_d;
  poly_item_t item_b_q;

  always_comb begin
    item_b_d             = item_a_q;
    item_b_d.yaw.acc_s   = mul_fin(pp_ys_q, 60) + sin_coef_i;
    item_b_d.yaw.acc_c   = mul_fin(pp_yc_q, 60) + cos_coef_i;
    item_b_d.pitch.acc_s = mul_fin(pp_ps_q, 60) + sin_coef_i;
    item_b_d.pitch.acc_c = mul_fin(pp_pc_q, 60) + cos_coef_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_a_q <= item_i;
      pp_ys_q  <= mul_pp(item_i.yaw.acc_s, item_i.yaw.x2);
      pp_yc_q  <= mul_pp(item_i.yaw.acc_c, item_i.yaw.x2);
      pp_ps_q  <= mul_pp(item_i.pitch.acc_s, item_i.pitch.x2);
      pp_pc_q  <= mul_pp(item_i.pitch.acc_c, item_i.pitch.x2);
      item_b_q <= item_b_d;
    end
  end

  assign valid_o = valid_b_q;
  assign item_o  = item_b_q;

endmodule

// File: hw/rtl/yaw_pitch_forward_vector_top.sv
// Throughput: one transaction per cycle; the whole pipeline advances together
// and stalls only while a finished result waits at the output register.
// The pipeline is a reciprocal quotient estimate with a 2-cell correction
// chain and a 6-cell polynomial chain.
// Reset (asynchronous, active low) clears all valid bits; data is not reset.
// Depends on ypfv_pkg, ypfv_div_cell, ypfv_poly_cell and the assertion header.
`include "yaw_pitch_forward_vector_top_assert.svh"

module yaw_pitch_forward_vector_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ypfv_pkg::ypfv_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ypfv_pkg::ypfv_out_t out_o
);
  import ypfv_pkg::*;

  localparam int NCELL = NUM_TERMS - 1;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [31:0]      corr;
    logic             neg;
  } red_lane_t;

  typedef struct packed {
    pp_t                pp_s;
    logic signed [63:0] c30;
    logic               flip;
  } fin_lane_t;

  logic en;

  logic      s0_valid_q;
  div_item_t s0_item_d;
  div_item_t s0_item_q;

  logic      es_valid_q;
  div_item_t es_item_d;
  div_item_t es_item_q;

  logic      er_valid_q;
  div_item_t er_item_d;
  div_item_t er_item_q;

  logic      dv_valid [NUM_FIX+1];
  div_item_t dv_item  [NUM_FIX+1];

  logic      r1_valid_q;
  red_lane_t r1_yaw_q;
  red_lane_t r1_pitch_q;

  logic       r2_valid_q;
  poly_item_t r2_item_d;
  poly_item_t r2_item_q;

  logic       xa_valid_q;
  poly_item_t xa_item_q;
  pp_t        xa_pp_y_q;
  pp_t        xa_pp_p_q;

  logic       xb_valid_q;
  poly_item_t xb_item_d;
  poly_item_t xb_item_q;

  logic       pc_valid [NCELL+1];
  poly_item_t pc_item  [NCELL+1];

  logic      fa_valid_q;
  fin_lane_t fa_yaw_q;
  fin_lane_t fa_pitch_q;

  logic               fb_valid_q;
  logic signed [63:0] fb_sy_q;
  logic signed [63:0] fb_cy_q;
  logic signed [63:0] fb_sp_q;
  logic signed [63:0] fb_cp_q;

  logic               va_valid_q;
  pp_t                va_pp_x_q;
  pp_t                va_pp_y_q;
  logic signed [63:0] va_sp_q;

  logic      out_valid_q;
  ypfv_out_t out_d;
  ypfv_out_t out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  function automatic div_lane_t prep_yaw(input logic signed [IN_W-1:0] a);
    div_lane_t   l;
    logic [63:0] mag;
    mag = a[IN_W-1] ? ((64'd1 << IN_W) - {{(64-IN_W){1'b0}}, a})
                    : {{(64-IN_W){1'b0}}, a};
    if (mag > YAW_LIMIT) begin
      mag = 64'd0;
    end
    mag    = mag << TO_Q32;
    l.rem  = REM_W'(mag + PI_Q32);
    l.quot = '0;
    l.neg  = a[IN_W-1];
    return l;
  endfunction

  function automatic div_lane_t prep_pitch(input logic signed [IN_W-1:0] a);
    div_lane_t   l;
    logic [63:0] mag;
    mag = a[IN_W-1] ? ((64'd1 << IN_W) - {{(64-IN_W){1'b0}}, a})
                    : {{(64-IN_W){1'b0}}, a};
    if (mag > (PITCH_LIM_Q32 >> TO_Q32)) begin
      mag = PITCH_LIM_Q32;
    end else begin
      mag = mag << TO_Q32;
    end
    if (mag > PITCH_LIM_Q32) begin
      mag = PITCH_LIM_Q32;
    end
    l.rem  = REM_W'(mag + PI_Q32);
    l.quot = '0;
    l.neg  = a[IN_W-1];
    return l;
  endfunction

  // The estimate never exceeds the true quotient and falls short of it by at
  // most two, which the correction cells make up.
  function automatic div_lane_t est_quot(input div_lane_t l);
    div_lane_t   o;
    logic [56:0] p;
    p      = {25'd0, l.rem[RECIP_SHIFT+31:RECIP_SHIFT]} * {32'd0, RECIP[RECIP_W-1:0]};
    o      = l;
    o.quot = p[QBITS+31:32];
    return o;
  endfunction

  function automatic div_lane_t first_rem(input div_lane_t l);
    div_lane_t        o;
    logic [55:0]      lo_p;
    logic [26:0]      hi_p;
    logic [REM_W-1:0] prod;
    lo_p  = {32'd0, l.quot} * {24'd0, TWO_PI_HI[31:0]};
    hi_p  = {3'd0, l.quot} * {24'd0, TWO_PI_HI[34:32]};
    prod  = {4'd0, lo_p} + {1'b0, hi_p, 32'd0};
    o     = l;
    o.rem = l.rem - prod;
    return o;
  endfunction

  function automatic red_lane_t reduce(input div_lane_t l);
    red_lane_t   o;
    logic [63:0] prod;
    prod   = {{(64-QBITS){1'b0}}, l.quot} * TWO_PI_LO;
    prod   = (prod + 64'h8000_0000) >> 32;
    o.rem  = l.rem;
    o.corr = prod[31:0];
    o.neg  = l.neg;
    return o;
  endfunction

  function automatic poly_lane_t fold(input red_lane_t l);
    poly_lane_t         o;
    logic signed [63:0] r;
    r = $signed({{(64-REM_W){1'b0}}, l.rem}) - $signed(PI_Q32)
        - $signed({32'd0, l.corr});
    if (l.neg) begin
      r = -r;
    end
    o.flip = 1'b0;
    if (r > $signed(HALF_PI_Q32)) begin
      r      = $signed(PI_Q32) - r;
      o.flip = 1'b1;
    end else if (r < -$signed(HALF_PI_Q32)) begin
      r      = -$signed(PI_Q32) - r;
      o.flip = 1'b1;
    end
    o.x     = r <<< 28;
    o.x2    = '0;
    o.acc_s = '0;
    o.acc_c = '0;
    return o;
  endfunction

  function automatic fin_lane_t fin_a(input poly_lane_t l);
    fin_lane_t o;
    o.pp_s = mul_pp(l.x, l.acc_s);
    o.c30  = shr_round(l.acc_c, 30);
    o.flip = l.flip;
    return o;
  endfunction

  always_comb begin
    s0_item_d.yaw   = prep_yaw(in_i.yaw_angle);
    s0_item_d.pitch = prep_pitch(in_i.pitch_angle);
  end

  always_comb begin
    es_item_d.yaw   = est_quot(s0_item_q.yaw);
    es_item_d.pitch = est_quot(s0_item_q.pitch);
  end

  always_comb begin
    er_item_d.yaw   = first_rem(es_item_q.yaw);
    er_item_d.pitch = first_rem(es_item_q.pitch);
  end

  always_comb begin
    r2_item_d.yaw   = fold(r1_yaw_q);
    r2_item_d.pitch = fold(r1_pitch_q);
  end

  always_comb begin
    xb_item_d             = xa_item_q;
    xb_item_d.yaw.x2      = mul_fin(xa_pp_y_q, 60);
    xb_item_d.pitch.x2    = mul_fin(xa_pp_p_q, 60);
    xb_item_d.yaw.acc_s   = SIN_COEF[0];
    xb_item_d.yaw.acc_c   = COS_COEF[0];
    xb_item_d.pitch.acc_s = SIN_COEF[0];
    xb_item_d.pitch.acc_c = COS_COEF[0];
  end

  always_comb begin
    out_d.forward_x = to_out(mul_fin(va_pp_x_q, 30));
    out_d.forward_y = to_out(mul_fin(va_pp_y_q, 30));
    out_d.forward_z = to_out(va_sp_q);
  end

  assign dv_valid[0] = er_valid_q;
  assign dv_item[0]  = er_item_q;

  for (genvar k = 0; k < NUM_FIX; k++) begin : g_div
    ypfv_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[k]),
      .div_i   (REM_W'(TWO_PI_HI)),
      .item_i  (dv_item[k]),
      .valid_o (dv_valid[k+1]),
      .item_o  (dv_item[k+1])
    );
  end

  assign pc_valid[0] = xb_valid_q;
  assign pc_item[0]  = xb_item_q;

  for (genvar k = 0; k < NCELL; k++) begin : g_poly
    ypfv_poly_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (pc_valid[k]),
      .sin_coef_i (SIN_COEF[k+1]),
      .cos_coef_i (COS_COEF[k+1]),
      .item_i     (pc_item[k]),
      .valid_o    (pc_valid[k+1]),
      .item_o     (pc_item[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      es_valid_q  <= 1'b0;
      er_valid_q  <= 1'b0;
      r1_valid_q  <= 1'b0;
      r2_valid_q  <= 1'b0;
      xa_valid_q  <= 1'b0;
      xb_valid_q  <= 1'b0;
      fa_valid_q  <= 1'b0;
      fb_valid_q  <= 1'b0;
      va_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q  <= in_valid_i;
      es_valid_q  <= s0_valid_q;
      er_valid_q  <= es_valid_q;
      r1_valid_q  <= dv_valid[NUM_FIX];
      r2_valid_q  <= r1_valid_q;
      xa_valid_q  <= r2_valid_q;
      xb_valid_q  <= xa_valid_q;
      fa_valid_q  <= pc_valid[NCELL];
      fb_valid_q  <= fa_valid_q;
      va_valid_q  <= fb_valid_q;
      out_valid_q <= va_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_item_q  <= s0_item_d;
      es_item_q  <= es_item_d;
      er_item_q  <= er_item_d;
      r1_yaw_q   <= reduce(dv_item[NUM_FIX].yaw);
      r1_pitch_q <= reduce(dv_item[NUM_FIX].pitch);
      r2_item_q  <= r2_item_d;
      xa_item_q  <= r2_item_q;
      xa_pp_y_q  <= mul_pp(r2_item_q.yaw.x, r2_item_q.yaw.x);
      xa_pp_p_q  <= mul_pp(r2_item_q.pitch.x, r2_item_q.pitch.x);
      xb_item_q  <= xb_item_d;
      fa_yaw_q   <= fin_a(pc_item[NCELL].yaw);
      fa_pitch_q <= fin_a(pc_item[NCELL].pitch);
      fb_sy_q    <= shr_round(mul_fin(fa_yaw_q.pp_s, 60), 30);
      fb_cy_q    <= fa_yaw_q.flip ? -fa_yaw_q.c30 : fa_yaw_q.c30;
      fb_sp_q    <= shr_round(mul_fin(fa_pitch_q.pp_s, 60), 30);
      fb_cp_q    <= fa_pitch_q.flip ? -fa_pitch_q.c30 : fa_pitch_q.c30;
      va_pp_x_q  <= mul_pp(fb_sy_q, fb_cp_q);
      va_pp_y_q  <= mul_pp(fb_cy_q, fb_cp_q);
      va_sp_q    <= fb_sp_q;
      out_q      <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `YPFV_ASSERT_IMP(a_div_rem_below_divisor, dv_valid[NUM_FIX],
    {4'd0, dv_item[NUM_FIX].yaw.rem} < TWO_PI_HI
      && {4'd0, dv_item[NUM_FIX].pitch.rem} < TWO_PI_HI,
    "Divider remainder is not below the divisor.")
  `YPFV_ASSERT_RANGE(a_forward_x_range, out_valid_o, out_o.forward_x,
    32'sd1 <<< OUT_FRAC_BITS, "forward_x exceeds unit range.")
  `YPFV_ASSERT_RANGE(a_forward_z_range, out_valid_o, out_o.forward_z,
    32'sd1 <<< OUT_FRAC_BITS, "forward_z exceeds unit range.")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for yaw_pitch_forward_vector_top: directed table and random
// angles, checked field by field against a fixed-point forward vector predictor.
// Depends on ypfv_pkg and the RTL of the block.
module tb_top;
  import ypfv_pkg::*;

  localparam int N_RANDOM = 1200;
  localparam logic [63:0] PITCH_IN_LIM = PITCH_LIM_Q32 >> TO_Q32;

  typedef struct {
    logic [IN_W-1:0] yaw;
    logic [IN_W-1:0] pitch;
    bit              typed;
    ypfv_out_t       vec;
  } vec_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  ypfv_in_t  in_i;
  logic      out_valid_o;
  logic      out_ready_i;
  ypfv_out_t out_o;

  ypfv_out_t    vec_expected [$];
  logic signed [63:0] sin_taylor [NUM_TERMS];
  logic signed [63:0] cos_taylor [NUM_TERMS];
  int           mismatches;

  yaw_pitch_forward_vector_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] with_sign(input logic [62:0] m, input logic neg);
    logic signed [63:0] s;
    s = {1'b0, m};
    return neg ? -s : s;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
                                                    input logic signed [63:0] b, input int n);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = (p + (128'd1 << (n - 1))) >> n;
    return with_sign(p[62:0], a[63] ^ b[63]);
  endfunction

  function automatic logic signed [63:0] shift_round(input logic signed [63:0] v, input int n);
    logic [63:0] t;
    t = (abs64(v) + (64'd1 << (n - 1))) >> n;
    return with_sign(t[62:0], v[63]);
  endfunction

  function automatic logic signed [63:0] inv_factorial(input logic signed [63:0] f);
    return ((64'sd1 <<< 60) + f / 2) / f;
  endfunction

  task automatic angle_sin_cos(input logic [63:0] m, input logic neg,
                               output logic signed [63:0] s30, output logic signed [63:0] c30);
    logic [63:0]        whole;
    logic signed [63:0] r;
    logic signed [63:0] x;
    logic signed [63:0] x2;
    logic signed [63:0] as;
    logic signed [63:0] ac;
    logic               flip;
    whole = (m + PI_Q32) / TWO_PI_HI;
    r = $signed(m) - $signed(whole) * $signed(TWO_PI_HI)
        - shift_round($signed(whole) * $signed(TWO_PI_LO), 32);
    flip = 1'b0;
    if (neg) begin
      r = -r;
    end
    if (r > $signed(HALF_PI_Q32)) begin
      r = $signed(PI_Q32) - r;
      flip = 1'b1;
    end else if (r < -$signed(HALF_PI_Q32)) begin
      r = -$signed(PI_Q32) - r;
      flip = 1'b1;
    end
    x = r <<< 28;
    x2 = mul_round(x, x, 60);
    as = sin_taylor[0];
    ac = cos_taylor[0];
    for (int i = 1; i < NUM_TERMS; i++) begin
      as = mul_round(as, x2, 60) + sin_taylor[i];
      ac = mul_round(ac, x2, 60) + cos_taylor[i];
    end
    s30 = shift_round(mul_round(x, as, 60), 30);
    c30 = shift_round(ac, 30);
    if (flip) begin
      c30 = -c30;
    end
  endtask

  function automatic logic signed [OUT_W-1:0] clamp_unit(input logic signed [63:0] v30);
    logic signed [63:0] v;
    logic signed [63:0] one;
    one = 64'sd1 <<< OUT_FRAC_BITS;
    v = (OUT_FRAC_BITS == 30) ? v30 : shift_round(v30, 30 - OUT_FRAC_BITS);
    if (v > one) begin
      v = one;
    end
    if (v < -one) begin
      v = -one;
    end
    return v[OUT_W-1:0];
  endfunction

  task automatic forward_vector(input ypfv_in_t a, output ypfv_out_t f);
    logic [63:0]        ymag;
    logic [63:0]        pmag;
    logic signed [63:0] sy;
    logic signed [63:0] cy;
    logic signed [63:0] sp;
    logic signed [63:0] cp;
    ymag = a.yaw_angle[IN_W-1] ? (64'd1 << IN_W) - {16'd0, a.yaw_angle}
                               : {16'd0, a.yaw_angle};
    pmag = a.pitch_angle[IN_W-1] ? (64'd1 << IN_W) - {16'd0, a.pitch_angle}
                                 : {16'd0, a.pitch_angle};
    if (ymag > YAW_LIMIT) begin
      ymag = 0;
    end
    ymag = ymag << TO_Q32;
    if (pmag > PITCH_IN_LIM) begin
      pmag = PITCH_LIM_Q32;
    end else begin
      pmag = pmag << TO_Q32;
    end
    if (pmag > PITCH_LIM_Q32) begin
      pmag = PITCH_LIM_Q32;
    end
    angle_sin_cos(pmag, a.pitch_angle[IN_W-1], sp, cp);
    angle_sin_cos(ymag, a.yaw_angle[IN_W-1], sy, cy);
    f.forward_x = clamp_unit(mul_round(sy, cp, 30));
    f.forward_y = clamp_unit(mul_round(cy, cp, 30));
    f.forward_z = clamp_unit(sp);
  endtask

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("error: %s expected %0d got %0d", what, $signed(want), $signed(got));
    mismatches++;
  endtask

  // Input monitor: predict every accepted transaction.
  always @(posedge clk_i) begin
    ypfv_out_t f;
    if (rst_ni && in_valid_i && in_ready_o) begin
      forward_vector(in_i, f);
      vec_expected.push_back(f);
    end
  end

  // Output monitor.
  always @(posedge clk_i) begin
    ypfv_out_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (vec_expected.size() == 0) begin
        report("unexpected result", 0, out_o.forward_x);
      end else begin
        w = vec_expected.pop_front();
        if (out_o.forward_x !== w.forward_x) report("forward_x", w.forward_x, out_o.forward_x);
        if (out_o.forward_y !== w.forward_y) report("forward_y", w.forward_y, out_o.forward_y);
        if (out_o.forward_z !== w.forward_z) report("forward_z", w.forward_z, out_o.forward_z);
      end
    end
  end

  // Receiver stalls in one of four modes, picked at random as rx_cycle advances.
  int unsigned rx_cycle;
  int unsigned rx_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cycle    <= 0;
      rx_mode     <= 0;
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 63) begin
        rx_mode <= $urandom_range(0, 3);
      end
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (rx_cycle % 8 < 5);
      endcase
    end
  end

  function automatic logic [IN_W-1:0] signed_pick(input logic [63:0] mag);
    logic [IN_W-1:0] v;
    v = mag[IN_W-1:0];
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  function automatic logic [IN_W-1:0] random_angle();
    case ($urandom_range(0, 19))
      0, 1, 2: return IN_W'({$urandom, $urandom});
      3, 4: return signed_pick(YAW_LIMIT + $urandom_range(0, 4) - 2);
      5, 6: return signed_pick(PITCH_IN_LIM + $urandom_range(0, 4) - 2);
      7, 8: return signed_pick(((HALF_PI_Q32 * $urandom_range(0, 8)) >> TO_Q32)
                               + $urandom_range(0, 2) - 1);
      9: return signed_pick({12'd0, $urandom_range(0, 100000), 20'd0} + 64'($urandom));
      default: return signed_pick(64'($urandom_range(0, 32'h0080_0000)));
    endcase
  endfunction

  task automatic send(input logic [IN_W-1:0] yaw, input logic [IN_W-1:0] pitch,
                      inout int burst_left);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_i <= '{yaw_angle: yaw, pitch_angle: pitch};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin
    vec_row_t rows [$];
    vec_row_t r;
    ypfv_out_t straight;
    int burst;
    logic [IN_W-1:0] y;
    logic [IN_W-1:0] p;
    sin_taylor[0] = inv_factorial(64'sd6227020800);
    sin_taylor[1] = -inv_factorial(64'sd39916800);
    sin_taylor[2] = inv_factorial(64'sd362880);
    sin_taylor[3] = -inv_factorial(64'sd5040);
    sin_taylor[4] = inv_factorial(64'sd120);
    sin_taylor[5] = -inv_factorial(64'sd6);
    sin_taylor[6] = 64'sd1 <<< 60;
    cos_taylor[0] = inv_factorial(64'sd479001600);
    cos_taylor[1] = -inv_factorial(64'sd3628800);
    cos_taylor[2] = inv_factorial(64'sd40320);
    cos_taylor[3] = -inv_factorial(64'sd720);
    cos_taylor[4] = inv_factorial(64'sd24);
    cos_taylor[5] = -inv_factorial(64'sd2);
    cos_taylor[6] = 64'sd1 <<< 60;

    mismatches = 0;
    in_valid_i = 1'b0;
    in_i       = '0;
    rst_ni     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    straight = '{forward_x: 32'sd0, forward_y: 32'sd1 << 30, forward_z: 32'sd0};
    rows.push_back('{48'd0, 48'd0, 1'b1, straight});
    rows.push_back('{48'h7FFF_FFFF_FFFF, 48'd0, 1'b1, straight});
    rows.push_back('{48'h8000_0000_0000, 48'd0, 1'b1, straight});
    rows.push_back('{YAW_LIMIT[IN_W-1:0] + 48'd1, 48'd0, 1'b1, straight});
    rows.push_back('{-(YAW_LIMIT[IN_W-1:0] + 48'd1), 48'd0, 1'b1, straight});
    rows.push_back('{YAW_LIMIT[IN_W-1:0], 48'd0, 1'b0, straight});
    rows.push_back('{-YAW_LIMIT[IN_W-1:0], 48'h7FFF_FFFF_FFFF, 1'b0, straight});
    rows.push_back('{48'd0, 48'h7FFF_FFFF_FFFF, 1'b0, straight});
    rows.push_back('{48'd0, 48'h8000_0000_0000, 1'b0, straight});
    rows.push_back('{48'd0, PITCH_IN_LIM[IN_W-1:0], 1'b0, straight});
    rows.push_back('{48'd0, PITCH_IN_LIM[IN_W-1:0] + 48'd1, 1'b0, straight});
    rows.push_back('{48'd0, -PITCH_IN_LIM[IN_W-1:0], 1'b0, straight});
    rows.push_back('{PI_Q32[IN_W+TO_Q32-1:TO_Q32], 48'd0, 1'b0, straight});
    rows.push_back('{-PI_Q32[IN_W+TO_Q32-1:TO_Q32], 48'd0, 1'b0, straight});
    rows.push_back('{HALF_PI_Q32[IN_W+TO_Q32-1:TO_Q32], 48'd0, 1'b0, straight});
    rows.push_back('{HALF_PI_Q32[IN_W+TO_Q32-1:TO_Q32] + 48'd1, 48'd100, 1'b0, straight});
    rows.push_back('{-TWO_PI_HI[IN_W+TO_Q32-1:TO_Q32], 48'hFFFF_FFFF_FFFF, 1'b0, straight});
    rows.push_back('{48'd1, 48'd1, 1'b0, straight});
    rows.push_back('{48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555, 1'b0, straight});
    rows.push_back('{48'h0000_0AAA_AAAA, 48'h0000_0010_0000, 1'b0, straight});

    burst = 0;
    foreach (rows[i]) begin
      r = rows[i];
      if (r.typed) begin
        forward_vector('{yaw_angle: r.yaw, pitch_angle: r.pitch}, straight);
        if (straight !== r.vec) report("table row", i, 0);
      end
      send(r.yaw, r.pitch, burst);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (vec_expected.size() != 0) @(posedge clk_i);
      end
      y = random_angle();
      p = random_angle();
      send(y, p, burst);
    end
    in_valid_i <= 1'b0;

    while (vec_expected.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ypfv_pkg.sv
hw/rtl/ypfv_div_cell.sv
hw/rtl/ypfv_poly_cell.sv
hw/rtl/yaw_pitch_forward_vector_top.sv
tb/tb_top.sv
